// File: design/urpd_pkg.sv
// ----------------------------------------------------------------------------
// urpd_pkg
// Shared types, character codes and helpers for the URI percent decoder
// and dot stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package urpd_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPercent = 2'd1,
    PhDigit   = 2'd2,
    PhUnused  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_nib(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.nib   = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.valid = 1'b1;
      r.nib   = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.valid = 1'b1;
      r.nib   = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic logic is_slash(input logic [7:0] c);
    return (c == ChSlash) || (c == ChBslash);
  endfunction

endpackage

`default_nettype wire

// File: design/uri_percent_decode_dot_strip_unit.sv
// Accepted transactions are registered into the per-transaction queue, and the
// single result register drains it to the output. Throughput: one input
// transaction per cycle while each yields one result and the output is not
// stalled; several results per transaction stall input until the last loads.
// Reset: asynchronous, active low; clears escape, slash and end state and
// empties the queue and result register.
// ----------------------------------------------------------------------------
// uri_percent_decode_dot_strip_unit
// Streams a URI one byte per transaction, decodes percent escapes, drops
// dot and slash runs after a slash and ends the string at NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_decode_dot_strip_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_present_o,
  output logic            out_last_o
);

  localparam int unsigned IdxW = $clog2(urpd_pkg::MaxRes);
  localparam int unsigned CntW = $clog2(urpd_pkg::MaxRes + 1);

  urpd_pkg::phase_e   phase_q, phase_d;
  logic [7:0]         held_q, held_d;
  logic               slash_q, slash_d;
  logic               ended_q, ended_d;

  urpd_pkg::res_t     pend_q [urpd_pkg::MaxRes];
  urpd_pkg::res_t     pend_d [urpd_pkg::MaxRes];
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    rd_q;
  logic [CntW-1:0]    remain;

  logic               out_valid_q;
  urpd_pkg::res_t     out_q;

  logic               out_adv;
  logic               load_out;
  logic               accept;

  logic [7:0]         cand_b [urpd_pkg::MaxRes];
  logic               cand_v [urpd_pkg::MaxRes];
  urpd_pkg::hex_t     hb;
  urpd_pkg::hex_t     hh;

  assign remain   = cnt_q - rd_q;
  assign out_adv  = !out_valid_q || !out_stall_i;
  assign load_out = out_adv && (remain != '0);
  assign in_stall_o = !((remain == '0) || ((remain == CntW'(1)) && out_adv));
  assign accept   = in_valid_i && !in_stall_o;

  assign hb = urpd_pkg::hex_nib(in_byte_i);
  assign hh = urpd_pkg::hex_nib(held_q);

  always_comb begin
    for (int i = 0; i < urpd_pkg::MaxRes; i++) begin
      cand_b[i] = urpd_pkg::ChNul;
      cand_v[i] = 1'b0;
    end
    phase_d = urpd_pkg::PhIdle;
    held_d  = held_q;
    unique case (phase_q)
      urpd_pkg::PhPercent: begin
        if (hb.valid) begin
          phase_d = urpd_pkg::PhDigit;
          held_d  = in_byte_i;
        end else begin
          cand_b[0] = urpd_pkg::ChPercent;
          cand_v[0] = 1'b1;
          if (in_byte_i == urpd_pkg::ChPercent) begin
            phase_d = urpd_pkg::PhPercent;
          end else begin
            cand_b[1] = in_byte_i;
            cand_v[1] = 1'b1;
          end
        end
      end
      urpd_pkg::PhDigit: begin
        if (hb.valid) begin
          cand_b[0] = {(hh.valid ? hh.nib : 4'h0), hb.nib};
          cand_v[0] = 1'b1;
        end else begin
          cand_b[0] = urpd_pkg::ChPercent;
          cand_v[0] = 1'b1;
          cand_b[1] = held_q;
          cand_v[1] = 1'b1;
          if (in_byte_i == urpd_pkg::ChPercent) begin
            phase_d = urpd_pkg::PhPercent;
          end else begin
            cand_b[2] = in_byte_i;
            cand_v[2] = 1'b1;
          end
        end
      end
      default: begin
        if (in_byte_i == urpd_pkg::ChPercent) begin
          phase_d = urpd_pkg::PhPercent;
        end else begin
          cand_b[0] = in_byte_i;
          cand_v[0] = 1'b1;
        end
      end
    endcase
    if (in_last_i) begin
      if (phase_d == urpd_pkg::PhPercent || phase_d == urpd_pkg::PhDigit) begin
        cand_b[2] = urpd_pkg::ChPercent;
        cand_v[2] = 1'b1;
      end
      if (phase_d == urpd_pkg::PhDigit) begin
        cand_b[3] = held_d;
        cand_v[3] = 1'b1;
      end
    end
  end

  // Strip dots and slashes after a slash, stop at NUL, pack kept bytes.
  always_comb begin
    logic            sl;
    logic            en;
    logic [CntW-1:0] k;
    logic            drop;
    sl   = slash_q;
    en   = ended_q;
    k    = '0;
    drop = 1'b0;
    for (int i = 0; i < urpd_pkg::MaxRes; i++) begin
      pend_d[i] = '0;
    end
    for (int i = 0; i < urpd_pkg::MaxRes; i++) begin
      if (cand_v[i] && !en) begin
        if (cand_b[i] == urpd_pkg::ChNul) begin
          en = 1'b1;
        end else begin
          drop = sl && (cand_b[i] == urpd_pkg::ChDot || urpd_pkg::is_slash(cand_b[i]));
          if (!drop) begin
            pend_d[k[IdxW-1:0]].data    = cand_b[i];
            pend_d[k[IdxW-1:0]].present = 1'b1;
            k  = k + CntW'(1);
            sl = urpd_pkg::is_slash(cand_b[i]);
          end
        end
      end
    end
    cnt_d = k;
    if (in_last_i) begin
      if (k == '0) begin
        pend_d[0].last = 1'b1;
        cnt_d          = CntW'(1);
      end else begin
        pend_d[IdxW'(k - CntW'(1))].last = 1'b1;
      end
    end
    slash_d = in_last_i ? 1'b0 : sl;
    ended_d = in_last_i ? 1'b0 : en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= urpd_pkg::PhIdle;
      held_q      <= '0;
      slash_q     <= 1'b0;
      ended_q     <= 1'b0;
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= load_out;
      end
      if (accept) begin
        phase_q <= in_last_i ? urpd_pkg::PhIdle : phase_d;
        held_q  <= in_last_i ? 8'h00 : held_d;
        slash_q <= slash_d;
        ended_q <= ended_d;
        cnt_q   <= cnt_d;
        rd_q    <= '0;
      end else if (load_out) begin
        rd_q <= rd_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= pend_q[rd_q[IdxW-1:0]];
    end
    if (accept) begin
      for (int i = 0; i < urpd_pkg::MaxRes; i++) begin
        pend_q[i] <= pend_d[i];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.data;
  assign out_present_o = out_q.present;
  assign out_last_o    = out_q.last;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CntW'(urpd_pkg::MaxRes)) && (rd_q <= cnt_q))
    else $error("result queue index out of range");

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_present_o) |-> out_last_o)
    else $error("bare marker without last flag");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (phase_q == urpd_pkg::PhIdle && !slash_q && !ended_q))
    else $error("state not cleared after final transaction");

  a_accept_only_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ((remain == '0) || (remain == CntW'(1) && load_out)))
    else $error("transaction accepted over undelivered results");
`endif

endmodule

`default_nettype wire
